@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL files; only the interpolator unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`endif
`endif

@@ hw/rtl/lkfi_pkg.sv @@
`timescale 1ns / 1ps
package lkfi_pkg;
  localparam int MaxPoints = 1024;
  localparam int AddrW = $clog2(MaxPoints);
  localparam int CntW = AddrW + 1;
  localparam int DivW = 64;
  localparam int DvsW = 33;
  localparam int DivCntW = $clog2(DivW);
  localparam int EntryW = 64;
  localparam logic [15:0] LookbackReset = 16'd90;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_STOP   = 2'd2,
    REQ_QUERY  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_DROP    = 2'd1,
    STAT_UNAVAIL = 2'd2,
    STAT_ZERO    = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic [31:0]        t;
  } entry_t;

  typedef struct packed {
    logic [31:0]        part;
    logic [31:0]        whole;
    logic signed [15:0] xa;
    logic signed [15:0] xb;
    logic signed [15:0] ya;
    logic signed [15:0] yb;
  } seg_t;
endpackage

@@ hw/rtl/lkfi_ram.sv @@
`timescale 1ns / 1ps
module lkfi_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ hw/rtl/lkfi_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module lkfi_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lkfi_pkg::DivW-1:0]    dividend_i,
  input  logic [lkfi_pkg::DvsW-1:0]    divisor_i,
  output logic                         done_o,
  output logic [lkfi_pkg::DivW-1:0]    quot_o,
  output logic [lkfi_pkg::DvsW-1:0]    rem_o
);
  logic                          busy_q;
  logic [lkfi_pkg::DivCntW-1:0]  cnt_q;
  logic [lkfi_pkg::DivW-1:0]     acc_q;
  logic [lkfi_pkg::DvsW-1:0]     rem_q, dvs_q;
  logic [lkfi_pkg::DvsW:0]       shifted;
  logic                          ge;

  assign shifted = {rem_q, acc_q[lkfi_pkg::DivW-1]};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == {lkfi_pkg::DivCntW{1'b1}}) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[lkfi_pkg::DivW-2:0], ge};
      rem_q <= ge ? lkfi_pkg::DvsW'(shifted - {1'b0, dvs_q})
                  : shifted[lkfi_pkg::DvsW-1:0];
    end
  end

  assign quot_o = acc_q;
  assign rem_o  = rem_q;
endmodule

@@ hw/rtl/looped_keyframe_interpolator_unit.sv @@
`timescale 1ns / 1ps
// Start, append and stop events go straight to the response state, which registers the
// result once the output is free. A query scans the point memory at one entry per cycle
// and uses a shared 64-step divider for loop wrap and interpolation. One item is in
// work at a time.
// Reset is asynchronous and active low; it empties the recording and sets lookback to 90.
`include "assert_macros.svh"
module looped_keyframe_interpolator_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // event_time, point_x, point_y
  input  logic [1:0]   s_axis_tuser,  // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // pos_x, pos_y, vel_x, vel_y, zero pad
  output logic [1:0]   m_axis_tuser,  // status
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i
);
  typedef enum logic [3:0] {
    ST_IDLE, ST_TOTAL, ST_WRAP, ST_WRAP_WAIT, ST_SCAN, ST_LERP, ST_DIV, ST_DIV_WAIT,
    ST_RESP
  } state_e;

  state_e                       state_q;
  logic [lkfi_pkg::CntW-1:0]    count_q, scan_q;
  logic                         recording_q, rvalid_q, have_prev_q, wsel_q, neg_q;
  logic [31:0]                  rec_origin_q, play_origin_q, total_q;
  logic [31:0]                  tv_q [2];
  logic [15:0]                  lookback_q;
  logic [1:0]                   status_q, job_q;
  logic [1:0]                   hit_q;
  lkfi_pkg::seg_t               seg_q [2];
  lkfi_pkg::entry_t             prev_q, rd_entry, wr_entry;
  logic signed [23:0]           res_q [4];
  logic [47:0]                  prod_q;

  logic                         accept, we;
  logic [lkfi_pkg::AddrW-1:0]   waddr, raddr;
  logic [lkfi_pkg::EntryW-1:0]  rdata;
  logic                         div_start, div_done;
  logic [lkfi_pkg::DivW-1:0]    dividend, quot;
  logic [lkfi_pkg::DvsW-1:0]    divisor, rem;
  logic [1:0]                   req;
  logic [31:0]                  in_time, wrap_val, tb_val;
  lkfi_pkg::seg_t               jseg;
  logic signed [15:0]           ja, jb;
  logic signed [16:0]           jdiff;
  logic [15:0]                  jmag;
  logic signed [24:0]           jbase, jres;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign req           = s_axis_tuser;
  assign in_time       = s_axis_tdata[31:0];
  assign rd_entry      = lkfi_pkg::entry_t'(rdata);

  assign wr_entry.t = (req == lkfi_pkg::REQ_START) ? 32'd0 : in_time - rec_origin_q;
  assign wr_entry.x = s_axis_tdata[47:32];
  assign wr_entry.y = s_axis_tdata[63:48];
  assign we    = accept && ((req == lkfi_pkg::REQ_START) ||
                 ((req == lkfi_pkg::REQ_APPEND) && (count_q < lkfi_pkg::CntW'(lkfi_pkg::MaxPoints))));
  assign waddr = (req == lkfi_pkg::REQ_START) ? '0 : count_q[lkfi_pkg::AddrW-1:0];
  assign raddr = (state_q == ST_SCAN) ? scan_q[lkfi_pkg::AddrW-1:0]
                                      : lkfi_pkg::AddrW'(count_q - 1'b1);

  lkfi_ram #(.Width(lkfi_pkg::EntryW), .Depth(lkfi_pkg::MaxPoints)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wr_entry),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign wrap_val = tv_q[wsel_q];
  assign tb_val   = (tv_q[0] >= {16'd0, lookback_q}) ? tv_q[0] - {16'd0, lookback_q} : 32'd0;

  assign jseg  = seg_q[job_q[1]];
  assign ja    = job_q[0] ? jseg.ya : jseg.xa;
  assign jb    = job_q[0] ? jseg.yb : jseg.xb;
  assign jdiff = 17'(jb) - 17'(ja);
  assign jmag  = 16'(jdiff[16] ? -jdiff : jdiff);
  assign jbase = 25'(ja) <<< 8;
  assign jres  = neg_q ? jbase - 25'(quot[24:0]) : jbase + 25'(quot[24:0]);

  assign div_start = ((state_q == ST_WRAP) && (wrap_val > total_q)) || (state_q == ST_DIV);
  assign dividend  = (state_q == ST_DIV) ? ({7'd0, prod_q, 9'd0} + {32'd0, jseg.whole})
                                         : {32'd0, wrap_val - 32'd1};
  assign divisor   = (state_q == ST_DIV) ? {jseg.whole, 1'b0} : {1'b0, total_q};

  lkfi_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(dividend),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      recording_q   <= 1'b0;
      rec_origin_q  <= '0;
      play_origin_q <= '0;
      lookback_q    <= lkfi_pkg::LookbackReset;
      m_axis_tvalid <= 1'b0;
      rvalid_q      <= 1'b0;
      have_prev_q   <= 1'b0;
      hit_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        lookback_q <= cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready && (state_q != ST_RESP)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            tv_q[0]  <= in_time - play_origin_q;
            status_q <= lkfi_pkg::STAT_OK;
            for (int k = 0; k < 4; k++) res_q[k] <= '0;
            state_q  <= ST_RESP;
            case (req)
              lkfi_pkg::REQ_START: begin
                recording_q  <= 1'b1;
                rec_origin_q <= in_time;
                count_q      <= lkfi_pkg::CntW'(1);
              end
              lkfi_pkg::REQ_APPEND: begin
                if (we) count_q <= count_q + 1'b1;
                else    status_q <= lkfi_pkg::STAT_DROP;
              end
              lkfi_pkg::REQ_STOP: begin
                recording_q   <= 1'b0;
                play_origin_q <= in_time;
              end
              default: begin
                if (recording_q || count_q < lkfi_pkg::CntW'(2)) begin
                  status_q <= lkfi_pkg::STAT_UNAVAIL;
                end else begin
                  state_q <= ST_TOTAL;
                end
              end
            endcase
          end
        end
        ST_TOTAL: begin
          total_q <= rd_entry.t;
          tv_q[1] <= tb_val;
          wsel_q  <= 1'b0;
          if (rd_entry.t == 32'd0) begin
            status_q <= lkfi_pkg::STAT_ZERO;
            state_q  <= ST_RESP;
          end else begin
            state_q <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          if (wrap_val > total_q) begin
            state_q <= ST_WRAP_WAIT;
          end else if (!wsel_q) begin
            wsel_q <= 1'b1;
          end else begin
            scan_q      <= '0;
            rvalid_q    <= 1'b0;
            have_prev_q <= 1'b0;
            hit_q       <= '0;
            state_q     <= ST_SCAN;
          end
        end
        ST_WRAP_WAIT: begin
          if (div_done) begin
            tv_q[wsel_q] <= rem[31:0] + 32'd1;
            state_q      <= ST_WRAP;
          end
        end
        ST_SCAN: begin
          rvalid_q <= scan_q < count_q;
          if (scan_q < count_q) scan_q <= scan_q + 1'b1;
          if (rvalid_q) begin
            prev_q      <= rd_entry;
            have_prev_q <= 1'b1;
            if (have_prev_q) begin
              for (int s = 0; s < 2; s++) begin
                if (tv_q[s] >= prev_q.t && tv_q[s] < rd_entry.t) begin
                  hit_q[s]       <= 1'b1;
                  seg_q[s].part  <= tv_q[s] - prev_q.t;
                  seg_q[s].whole <= rd_entry.t - prev_q.t;
                  seg_q[s].xa    <= prev_q.x;
                  seg_q[s].xb    <= rd_entry.x;
                  seg_q[s].ya    <= prev_q.y;
                  seg_q[s].yb    <= rd_entry.y;
                end
              end
            end
          end else if (scan_q == count_q) begin
            job_q   <= '0;
            state_q <= ST_LERP;
          end
        end
        ST_LERP: begin
          if (hit_q[job_q[1]]) begin
            prod_q  <= 48'(jmag) * 48'(jseg.part);
            neg_q   <= jdiff[16];
            state_q <= ST_DIV;
          end else begin
            res_q[job_q] <= '0;
            job_q        <= job_q + 1'b1;
            if (job_q == 2'd3) begin
              status_q <= hit_q[0] ? lkfi_pkg::STAT_OK : lkfi_pkg::STAT_UNAVAIL;
              state_q  <= ST_RESP;
            end
          end
        end
        ST_DIV: begin
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            res_q[job_q] <= jres[23:0];
            job_q        <= job_q + 1'b1;
            if (job_q == 2'd3) begin
              status_q <= hit_q[0] ? lkfi_pkg::STAT_OK : lkfi_pkg::STAT_UNAVAIL;
              state_q  <= ST_RESP;
            end else begin
              state_q <= ST_LERP;
            end
          end
        end
        ST_RESP: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= status_q;
            m_axis_tdata  <= {6'd0,
                              25'(res_q[1]) - 25'(res_q[3]),
                              25'(res_q[0]) - 25'(res_q[2]),
                              res_q[1], res_q[0]};
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= lkfi_pkg::CntW'(lkfi_pkg::MaxPoints))
  `ASSERT_IMPLIES(a_div_idle_start, clk_i, rst_ni, div_start, !$past(div_start))
  `ASSERT_IMPLIES(a_drop_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == lkfi_pkg::STAT_DROP, m_axis_tdata == '0)
endmodule
